[sv/tgp_pkg.sv]
// Shared types, register indexes and helper functions for the glyph placer.
package tgp_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned WideW  = 26;

  localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [2:0] REG_WIDTH_LIMIT  = 3'd2;
  localparam logic [2:0] REG_HEIGHT_LIMIT = 3'd3;
  localparam logic [2:0] REG_COLUMN_COUNT = 3'd4;
  localparam logic [2:0] REG_ADVANCE      = 3'd5;
  localparam logic [2:0] REG_LINE_HEIGHT  = 3'd6;

  localparam logic [7:0] CHAR_TAB        = 8'd9;
  localparam logic [7:0] CHAR_NEWLINE    = 8'd10;
  localparam logic [7:0] FIRST_PRINTABLE = 8'd32;
  localparam logic [6:0] GLYPH_FALLBACK  = 7'd95;
  localparam logic [3:0] TAB_STOP        = 4'd8;

  typedef struct packed {
    logic signed [CoordW-1:0] origin_x;
    logic signed [CoordW-1:0] origin_y;
    logic [22:0]              width_limit;
    logic [22:0]              height_limit;
    logic [7:0]               column_count;
    logic [15:0]              advance;
    logic [15:0]              line_height;
  } tgp_cfg_t;

  typedef struct packed {
    logic                     draw;
    logic [3:0]               glyph_col;
    logic [2:0]               glyph_row;
    logic signed [CoordW-1:0] pen_x;
    logic signed [CoordW-1:0] pen_y;
    logic [15:0]              line_count;
    logic                     halted;
  } tgp_result_t;

  function automatic logic signed [CoordW-1:0] sat24(input logic signed [WideW-1:0] v);
    logic signed [CoordW-1:0] r;
    if (v > 26'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -26'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [WideW-1:0] wide(input logic signed [CoordW-1:0] v);
    return {{(WideW-CoordW){v[CoordW-1]}}, v};
  endfunction

endpackage

[sv/text_layout_glyph_placer_core.sv]
// Top level of the glyph placer: input register, layout step and result register.
// One character is taken per transfer and gives exactly one result transfer. Each item
// sits in the input register, where the layout step updates the pen and column
// state, and then waits in the result register; a new character can be taken every
// cycle while the output side is ready, so sustained throughput is then one item per
// clock. Configuration writes take effect on the next cycle and should be made only
// while no item is in flight.
module text_layout_glyph_placer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // char_code
  input  logic        s_axis_tuser,  // first
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata   // draw, glyph_col, glyph_row, pen_x, pen_y,
                                     // line_count, halted, zero padding
);
  import tgp_pkg::*;

  tgp_cfg_t    cfg;
  tgp_result_t result;

  logic       in_valid_q;
  logic [7:0] code_q;
  logic       first_q;
  logic       out_valid_q;
  tgp_result_t out_q;
  logic       out_load;

  assign out_load      = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || out_load;

  tgp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  tgp_layout u_layout (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .step_i     (out_load),
    .char_code_i(code_q),
    .first_i    (first_q),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      code_q  <= s_axis_tdata;
      first_q <= s_axis_tuser;
    end
    if (out_load) out_q <= result;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_q.halted, out_q.line_count, out_q.pen_y, out_q.pen_x,
                          out_q.glyph_row, out_q.glyph_col, out_q.draw};

  a_halt_no_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[72]) |-> !m_axis_tdata[0])
    else $error("glyph drawn while halted");

  a_lines_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[71:56] != 16'd0))
    else $error("line count is zero");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:5] <= 3'd5))
    else $error("glyph row out of atlas");

endmodule

[sv/tgp_cfg_regs.sv]
// Configuration register bank of the glyph placer.
module tgp_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_addr_i,
  input  logic [23:0]       cfg_wdata_i,
  output tgp_pkg::tgp_cfg_t cfg_o
);
  import tgp_pkg::*;

  tgp_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_ORIGIN_X:     cfg_d.origin_x     = cfg_wdata_i;
        REG_ORIGIN_Y:     cfg_d.origin_y     = cfg_wdata_i;
        REG_WIDTH_LIMIT:  cfg_d.width_limit  = cfg_wdata_i[22:0];
        REG_HEIGHT_LIMIT: cfg_d.height_limit = cfg_wdata_i[22:0];
        REG_COLUMN_COUNT: cfg_d.column_count = cfg_wdata_i[7:0];
        REG_ADVANCE:      cfg_d.advance      = cfg_wdata_i[15:0];
        REG_LINE_HEIGHT:  cfg_d.line_height  = cfg_wdata_i[15:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{origin_x: '0, origin_y: '0, width_limit: '0, height_limit: '0,
                 column_count: 8'd1, advance: '0, line_height: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/tgp_layout.sv]
// Layout state registers and the single-pass next-state and result logic.
module tgp_layout (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tgp_pkg::tgp_cfg_t    cfg_i,
  input  logic                 step_i,
  input  logic [7:0]           char_code_i,
  input  logic                 first_i,
  output tgp_pkg::tgp_result_t result_o
);
  import tgp_pkg::*;

  logic signed [CoordW-1:0] clx_q, clx_d, bx_q, bx_d, cx_q, cx_d, cy_q, cy_d;
  logic [2:0]  tp_q, tp_d;
  logic [7:0]  cl_q, cl_d;
  logic [15:0] lu_q, lu_d;
  logic        st_q, st_d;

  logic signed [WideW-1:0] adv_w, lh_w, wl_w, hl_w, tab_w;
  logic [3:0]  tab_steps;
  logic [19:0] tab_adv;
  logic        draw;
  logic [6:0]  glyph;

  assign adv_w = $signed({10'b0, cfg_i.advance});
  assign lh_w  = $signed({10'b0, cfg_i.line_height});
  assign wl_w  = $signed({3'b0, cfg_i.width_limit});
  assign hl_w  = $signed({3'b0, cfg_i.height_limit});

  always_comb begin
    clx_d = clx_q;
    bx_d  = bx_q;
    cx_d  = cx_q;
    cy_d  = cy_q;
    tp_d  = tp_q;
    cl_d  = cl_q;
    lu_d  = lu_q;
    st_d  = st_q;
    draw  = 1'b0;
    glyph = '0;
    tab_steps = '0;
    tab_adv = '0;
    tab_w = '0;

    if (first_i) begin
      clx_d = cfg_i.origin_x;
      bx_d  = sat24(wide(cfg_i.origin_x) + wl_w);
      cx_d  = cfg_i.origin_x;
      cy_d  = cfg_i.origin_y;
      tp_d  = '0;
      cl_d  = cfg_i.column_count;
      lu_d  = 16'd1;
      st_d  = 1'b0;
    end

    if (!st_d) begin
      if (char_code_i == CHAR_TAB) begin
        tab_steps = TAB_STOP - {1'b0, tp_d};
        tab_adv   = {16'b0, tab_steps} * {4'b0, cfg_i.advance};
        tab_w     = $signed({6'b0, tab_adv});
        cx_d      = sat24(wide(cx_d) + tab_w);
        tp_d      = '0;
      end else if (char_code_i == CHAR_NEWLINE) begin
        cx_d = clx_d;
        cy_d = sat24(wide(cy_d) - lh_w);
        tp_d = '0;
        if (lu_d != 16'hFFFF) lu_d = lu_d + 16'd1;
      end else begin
        if (char_code_i >= FIRST_PRINTABLE && !char_code_i[7]) begin
          glyph = char_code_i[6:0] - FIRST_PRINTABLE[6:0];
        end else begin
          glyph = GLYPH_FALLBACK;
        end
        if (wide(cx_d) + adv_w >= wide(bx_d)) begin
          cx_d = clx_d;
          cy_d = sat24(wide(cy_d) - lh_w);
          tp_d = '0;
          if (lu_d != 16'hFFFF) lu_d = lu_d + 16'd1;
        end
        if (wide(cy_d) - lh_w < wide(cfg_i.origin_y) - hl_w) begin
          if (cl_d > 8'd1) begin
            cl_d  = cl_d - 8'd1;
            clx_d = sat24(wide(clx_d) + wl_w);
            bx_d  = sat24(wide(clx_d) + wl_w);
            cx_d  = clx_d;
            cy_d  = cfg_i.origin_y;
          end else begin
            st_d = 1'b1;
          end
        end
        draw = !st_d;
      end
    end

    result_o.draw       = draw;
    result_o.glyph_col  = draw ? glyph[3:0] : 4'd0;
    result_o.glyph_row  = draw ? glyph[6:4] : 3'd0;
    result_o.pen_x      = cx_d;
    result_o.pen_y      = cy_d;

    if (draw) begin
      cx_d = sat24(wide(cx_d) + adv_w);
      tp_d = tp_d + 3'd1;
    end

    result_o.line_count = lu_d;
    result_o.halted     = st_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clx_q <= '0;
      bx_q  <= '0;
      cx_q  <= '0;
      cy_q  <= '0;
      tp_q  <= '0;
      cl_q  <= 8'd1;
      lu_q  <= 16'd1;
      st_q  <= 1'b0;
    end else if (step_i) begin
      clx_q <= clx_d;
      bx_q  <= bx_d;
      cx_q  <= cx_d;
      cy_q  <= cy_d;
      tp_q  <= tp_d;
      cl_q  <= cl_d;
      lu_q  <= lu_d;
      st_q  <= st_d;
    end
  end

endmodule

[tb/testbench.sv]
// Self-checking testbench for the glyph placer: predicts every placement and compares it.
module testbench;
  import tgp_pkg::*;

  localparam longint COORD_TOP    = 64'sd8388607;
  localparam longint COORD_BOTTOM = -64'sd8388608;
  localparam int     REPORT_LIMIT = 100;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_addr_i = '0;
  logic [23:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;

  text_layout_glyph_placer_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  tgp_cfg_t    layout_cfg;
  longint      col_left_x, col_border_x, pen_x_q, pen_y_q;
  logic [2:0]  tab_phase_q;
  logic [7:0]  cols_left_q;
  logic [15:0] lines_q;
  logic        halted_q;

  tgp_result_t pending_glyphs[$];
  int          mismatches = 0;
  bit          idle_on = 1'b1;
  int          hold_request = 0;
  int          sink_stall = 0;

  function automatic longint clamp24(input longint v);
    if (v > COORD_TOP) return COORD_TOP;
    if (v < COORD_BOTTOM) return COORD_BOTTOM;
    return v;
  endfunction

  function automatic void start_line();
    pen_x_q = col_left_x;
    pen_y_q = clamp24(pen_y_q - longint'(layout_cfg.line_height));
    tab_phase_q = '0;
    if (lines_q != 16'hFFFF) lines_q = lines_q + 16'd1;
  endfunction

  function automatic tgp_result_t place_glyph(input logic [7:0] code, input logic first);
    tgp_result_t r;
    logic [6:0]  glyph;
    logic        placed;
    longint      ox, oy, wl, hl, adv, lh, px, py;
    ox = longint'($signed(layout_cfg.origin_x));
    oy = longint'($signed(layout_cfg.origin_y));
    wl = longint'(layout_cfg.width_limit);
    hl = longint'(layout_cfg.height_limit);
    adv = longint'(layout_cfg.advance);
    lh = longint'(layout_cfg.line_height);
    glyph = '0;
    placed = 1'b0;
    if (first) begin
      col_left_x = ox;
      col_border_x = clamp24(ox + wl);
      pen_x_q = ox;
      pen_y_q = oy;
      tab_phase_q = '0;
      cols_left_q = layout_cfg.column_count;
      lines_q = 16'd1;
      halted_q = 1'b0;
    end
    if (!halted_q) begin
      if (code == CHAR_TAB) begin
        pen_x_q = clamp24(pen_x_q + (longint'(TAB_STOP) - longint'(tab_phase_q)) * adv);
        tab_phase_q = '0;
      end else if (code == CHAR_NEWLINE) begin
        start_line();
      end else begin
        glyph = (!code[7] && code >= FIRST_PRINTABLE) ? 7'(code - FIRST_PRINTABLE)
                                                        : GLYPH_FALLBACK;
        if (pen_x_q + adv >= col_border_x) start_line();
        if (pen_y_q - lh < oy - hl) begin
          if (cols_left_q > 8'd1) begin
            cols_left_q = cols_left_q - 8'd1;
            col_left_x = clamp24(col_left_x + wl);
            col_border_x = clamp24(col_left_x + wl);
            pen_x_q = col_left_x;
            pen_y_q = oy;
          end else begin
            halted_q = 1'b1;
          end
        end
        placed = !halted_q;
      end
    end
    px = pen_x_q;
    py = pen_y_q;
    if (placed) begin
      pen_x_q = clamp24(pen_x_q + adv);
      tab_phase_q = tab_phase_q + 3'd1;
    end
    r.draw = placed;
    r.glyph_col = placed ? glyph[3:0] : 4'd0;
    r.glyph_row = placed ? glyph[6:4] : 3'd0;
    r.pen_x = px[23:0];
    r.pen_y = py[23:0];
    r.line_count = lines_q;
    r.halted = halted_q;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic compare_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
    if (want !== got) begin
      if (mismatches < REPORT_LIMIT) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
      end
      mismatches++;
    end
  endtask

  task automatic check_placement(input logic [79:0] word);
    tgp_result_t due;
    if (pending_glyphs.size() == 0) begin
      if (mismatches < REPORT_LIMIT) $error("result %h arrived with nothing expected", word);
      mismatches++;
      return;
    end
    due = pending_glyphs.pop_front();
    compare_field("draw", 24'(due.draw), 24'(word[0]));
    compare_field("glyph_col", 24'(due.glyph_col), 24'(word[4:1]));
    compare_field("glyph_row", 24'(due.glyph_row), 24'(word[7:5]));
    compare_field("pen_x", due.pen_x, word[31:8]);
    compare_field("pen_y", due.pen_y, word[55:32]);
    compare_field("line_count", 24'(due.line_count), 24'(word[71:56]));
    compare_field("halted", 24'(due.halted), 24'(word[72]));
    compare_field("padding", '0, 24'(word[79:73]));
  endtask

  // Result side: check each transfer, then decide whether to accept on the next edge.
  always @(posedge clk_i) begin
    if (m_axis_tvalid === 1'b1 && m_axis_tready) check_placement(m_axis_tdata);
    if (hold_request > 0) begin
      sink_stall = hold_request;
      hold_request = 0;
    end
    if (sink_stall > 0) begin
      m_axis_tready <= 1'b0;
      sink_stall--;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) sink_stall = pick_gap();
    end
  end

  task automatic feed_char(input logic [7:0] code, input logic first);
    int gap;
    s_axis_tdata <= code;
    s_axis_tuser <= first;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_glyphs.push_back(place_glyph(code, first));
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_glyphs.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_ORIGIN_X:     layout_cfg.origin_x = val;
      REG_ORIGIN_Y:     layout_cfg.origin_y = val;
      REG_WIDTH_LIMIT:  layout_cfg.width_limit = val[22:0];
      REG_HEIGHT_LIMIT: layout_cfg.height_limit = val[22:0];
      REG_COLUMN_COUNT: layout_cfg.column_count = val[7:0];
      REG_ADVANCE:      layout_cfg.advance = val[15:0];
      REG_LINE_HEIGHT:  layout_cfg.line_height = val[15:0];
      default: ;
    endcase
  endtask

  // Unused upper bits of the write data carry noise that the block must ignore.
  task automatic apply_layout(input tgp_cfg_t c);
    drain_results();
    write_reg(REG_ORIGIN_X, c.origin_x);
    write_reg(REG_ORIGIN_Y, c.origin_y);
    write_reg(REG_WIDTH_LIMIT, {1'($urandom), c.width_limit});
    write_reg(REG_HEIGHT_LIMIT, {1'($urandom), c.height_limit});
    write_reg(REG_COLUMN_COUNT, {16'($urandom), c.column_count});
    write_reg(REG_ADVANCE, {8'($urandom), c.advance});
    write_reg(REG_LINE_HEIGHT, {8'($urandom), c.line_height});
    cfg_we_i <= 1'b0;
  endtask

  function automatic tgp_cfg_t make_layout(input logic [23:0] ox, input logic [23:0] oy,
                                           input logic [22:0] wl, input logic [22:0] hl,
                                           input logic [7:0] cols, input logic [15:0] adv,
                                           input logic [15:0] lh);
    tgp_cfg_t c;
    c.origin_x = ox;
    c.origin_y = oy;
    c.width_limit = wl;
    c.height_limit = hl;
    c.column_count = cols;
    c.advance = adv;
    c.line_height = lh;
    return c;
  endfunction

  // Small layouts make wraps, column moves and halts frequent; wild ones use every bit.
  function automatic tgp_cfg_t random_layout(input bit wild);
    tgp_cfg_t c;
    if (wild) begin
      c.origin_x = 24'($urandom);
      c.origin_y = 24'($urandom);
      c.width_limit = 23'($urandom);
      c.height_limit = 23'($urandom);
      c.column_count = 8'($urandom);
      c.advance = 16'($urandom);
      c.line_height = 16'($urandom);
    end else begin
      c.advance = 16'($urandom_range(0, 1024));
      c.width_limit = 23'(c.advance * $urandom_range(0, 24) + $urandom_range(0, 255));
      c.line_height = 16'($urandom_range(0, 1024));
      c.height_limit = 23'(c.line_height * $urandom_range(0, 8) + $urandom_range(0, 255));
      c.column_count = 8'($urandom_range(0, 4));
      if ($urandom_range(0, 1) == 0) begin
        c.origin_x = 24'($urandom);
        c.origin_y = 24'($urandom);
      end else begin
        c.origin_x = 24'($urandom_range(0, 8191)) - 24'd4096;
        c.origin_y = 24'($urandom_range(0, 8191)) - 24'd4096;
      end
    end
    return c;
  endfunction

  task automatic test_unstarted_stream();
    feed_char("A", 1'b0);
    feed_char(CHAR_TAB, 1'b0);
    feed_char(CHAR_NEWLINE, 1'b0);
    feed_char("z", 1'b0);
  endtask

  task automatic test_glyph_codes();
    apply_layout(make_layout(24'h000100, 24'h001000, 23'h100000, 23'h100000,
                             8'd2, 16'h0800, 16'h1000));
    feed_char(" ", 1'b1);
    feed_char(8'd0, 1'b0);
    feed_char(8'd31, 1'b0);
    feed_char(8'd126, 1'b0);
    feed_char(8'd127, 1'b0);
    feed_char(8'd128, 1'b0);
    feed_char(8'd255, 1'b0);
    feed_char(CHAR_TAB, 1'b0);
    feed_char(CHAR_NEWLINE, 1'b0);
  endtask

  task automatic test_wrap_and_columns();
    apply_layout(make_layout(24'hFFF000, 24'h000400, 23'h000300, 23'h000200,
                             8'd2, 16'h0100, 16'h0200));
    feed_char("A", 1'b1);
    feed_char(CHAR_TAB, 1'b0);
    feed_char("B", 1'b0);
    feed_char("C", 1'b0);
    feed_char("D", 1'b0);
    feed_char("E", 1'b0);
    feed_char("F", 1'b0);
    feed_char(CHAR_NEWLINE, 1'b0);
    feed_char(CHAR_NEWLINE, 1'b1);
    feed_char("G", 1'b0);
    apply_layout(make_layout(24'h000000, 24'h000000, 23'h000300, 23'h000000,
                             8'd0, 16'h0100, 16'h0200));
    feed_char("H", 1'b1);
    feed_char("I", 1'b0);
  endtask

  task automatic test_coordinate_limits();
    apply_layout(make_layout(24'h7FFF00, 24'h800000, 23'h7FFFFF, 23'h7FFFFF,
                             8'hFF, 16'hFFFF, 16'hFFFF));
    feed_char("M", 1'b1);
    feed_char(CHAR_TAB, 1'b0);
    feed_char(CHAR_NEWLINE, 1'b0);
    feed_char("N", 1'b0);
    apply_layout(make_layout(24'h7FF000, 24'h000000, 23'h400000, 23'h000000,
                             8'd3, 16'h0100, 16'h0001));
    feed_char("a", 1'b1);
    feed_char("b", 1'b0);
    feed_char("c", 1'b0);
  endtask

  task automatic test_line_counting();
    int k;
    apply_layout(make_layout('0, '0, '0, '0, 8'd1, '0, '0));
    idle_on = 1'b0;
    feed_char(CHAR_NEWLINE, 1'b1);
    for (k = 0; k < 40; k++) feed_char(CHAR_NEWLINE, 1'b0);
    feed_char("~", 1'b0);
    idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    int k;
    apply_layout(random_layout(1'b0));
    idle_on = 1'b0;
    hold_request = 300;
    feed_char(8'($urandom_range(32, 127)), 1'b1);
    for (k = 0; k < 40; k++) feed_char(8'($urandom_range(32, 127)), 1'b0);
    idle_on = 1'b1;
    drain_results();
    for (k = 0; k < 20; k++) feed_char(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic test_random_strings();
    int         phase, fed, len, k, r;
    logic [7:0] code;
    logic       first;
    for (phase = 0; phase < 8; phase++) begin
      apply_layout(random_layout(phase % 4 == 3));
      idle_on = (phase % 3 != 1);
      fed = 0;
      while (fed < 140) begin
        len = $urandom_range(1, 40);
        for (k = 0; k < len; k++) begin
          r = $urandom_range(0, 99);
          if (r < 72) code = 8'($urandom_range(32, 127));
          else if (r < 80) code = CHAR_TAB;
          else if (r < 90) code = CHAR_NEWLINE;
          else code = 8'($urandom);
          if (k == 0) first = ($urandom_range(0, 19) != 0);
          else first = ($urandom_range(0, 49) == 0);
          feed_char(code, first);
          fed++;
        end
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    layout_cfg = '0;
    layout_cfg.column_count = 8'd1;
    col_left_x = 0;
    col_border_x = 0;
    pen_x_q = 0;
    pen_y_q = 0;
    tab_phase_q = '0;
    cols_left_q = 8'd1;
    lines_q = 16'd1;
    halted_q = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_unstarted_stream();
    test_glyph_codes();
    test_wrap_and_columns();
    test_coordinate_limits();
    test_line_counting();
    test_backpressure();
    test_random_strings();
    drain_results();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // About 1.4k items, each allowed the longest gaps on both sides, with ample margin.
  initial begin
    #40000000;
    $display("tb: failure");
    $finish;
  end

endmodule
